// ===== hdl/pcwq_pkg.sv =====
// Shared types, constants and helpers of the per-channel weight quantizer.
// No dependencies; used by every pcwq module and by the top level.
package pcwq_pkg;

  localparam int ROW_MAX = 32;
  localparam int IDX_W   = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int CNT_W   = $clog2(ROW_MAX + 1);
  localparam int ADDR_W  = IDX_W + 1;            // bank bit on top of row index
  localparam int SUM_W   = 22;                   // signed sum of codes of one row
  localparam int DQ_W    = 49;                   // divider dividend / quotient
  localparam int DR_W    = 34;                   // divider divisor / remainder
  localparam int STEP_W  = 6;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SHIFT = 2'd2;

  localparam logic [50:0] MAG_CAP = 51'd1 << 50;
  localparam logic signed [52:0] FB_MAX = 53'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [52:0] FB_MIN = -53'sh0_8000_0000_0000;

  typedef struct packed {
    logic [4:0]  bit_width;
    logic [31:0] input_scale;
    logic [31:0] input_shift;
  } cfg_t;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic [31:0]      maxabs;
    logic [31:0]      bias;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DR_W-1:0]   rem0;
    logic [DQ_W-1:0]   dvd;
    logic [DR_W-1:0]   divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DQ_W-1:0] quot;
    logic [DR_W-1:0] rem;
  } div_res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_CGO, ST_CWAIT, ST_CEMIT,
    ST_SMUL, ST_SCGO, ST_SCWAIT, ST_AGO, ST_AWAIT,
    ST_PMUL1, ST_PMUL2, ST_FGO, ST_FWAIT, ST_MAG, ST_FB, ST_SEMIT
  } state_t;

  // largest positive code for a bit width, width clamped to 2..16
  function automatic logic [14:0] qmax_of(input logic [4:0] bw);
    logic [4:0] b;
    b = bw;
    if (b < 5'd2) b = 5'd2;
    if (b > 5'd16) b = 5'd16;
    return 15'((17'd1 << (b - 5'd1)) - 17'd1);
  endfunction

endpackage

// ===== hdl/pcwq_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on pcwq_pkg (div_req_t, div_res_t).
module pcwq_div (
  input  logic               clk,
  input  logic               rst,
  input  pcwq_pkg::div_req_t req,
  output pcwq_pkg::div_res_t res
);

  logic [pcwq_pkg::DR_W-1:0]   rem;
  logic [pcwq_pkg::DQ_W-1:0]   dvd;
  logic [pcwq_pkg::DQ_W-1:0]   quot;
  logic [pcwq_pkg::DR_W-1:0]   divisor;
  logic [pcwq_pkg::STEP_W-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [pcwq_pkg::DR_W:0]     trial;
  logic                        ge;

  assign trial = {rem, dvd[pcwq_pkg::DQ_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pcwq_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem0;
      dvd     <= req.dvd;
      divisor <= req.divisor;
      quot    <= '0;
    end else if (busy) begin
      rem  <= ge ? pcwq_pkg::DR_W'(trial - {1'b0, divisor}) : trial[pcwq_pkg::DR_W-1:0];
      quot <= {quot[pcwq_pkg::DQ_W-2:0], ge};
      dvd  <= {dvd[pcwq_pkg::DQ_W-2:0], 1'b0};
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem;

endmodule

// ===== hdl/pcwq_row_buf.sv =====
// Two-bank row store: front writes one bank while the back replays the other.
// Depends on pcwq_pkg (address width).
module pcwq_row_buf (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [pcwq_pkg::ADDR_W-1:0] wr_addr,
  input  logic [31:0]                 wr_data,
  input  logic                        rd_en,
  input  logic [pcwq_pkg::ADDR_W-1:0] rd_addr,
  output logic [31:0]                 rd_data
);

  logic [31:0] mem [2**pcwq_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/pcwq_front.sv =====
// Intake: stores weights, tracks the row's largest magnitude and queues
// closed rows for the back end. Depends on pcwq_pkg (job_t, sizes).
module pcwq_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,
  input  logic                        s_axis_tlast,
  output logic                        wr_en,
  output logic [pcwq_pkg::ADDR_W-1:0] wr_addr,
  output logic [31:0]                 wr_data,
  output logic                        job_valid,
  output pcwq_pkg::job_t              job,
  input  logic                        job_pop
);

  logic [pcwq_pkg::CNT_W-1:0] row_count;
  logic [31:0]                max_magnitude;
  logic                       bank;
  pcwq_pkg::job_t             q_mem [2];
  logic                       q_wr;
  logic                       q_rd;
  logic [1:0]                 q_cnt;

  logic        accept;
  logic        stored;
  logic [31:0] w;
  logic [31:0] wm;
  logic [31:0] max_next;
  logic [pcwq_pkg::CNT_W-1:0] count_next;
  logic        push;

  assign s_axis_tready = q_cnt != 2'd2;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign w        = s_axis_tdata[31:0];
  assign wm       = w[31] ? 32'(32'd0 - w) : w;
  assign stored   = row_count < pcwq_pkg::CNT_W'(pcwq_pkg::ROW_MAX);
  assign max_next = (stored && wm > max_magnitude) ? wm : max_magnitude;
  assign count_next = stored ? row_count + 1'b1 : row_count;
  assign push     = accept && s_axis_tlast;

  assign wr_en   = accept && stored;
  assign wr_addr = {bank, row_count[pcwq_pkg::IDX_W-1:0]};
  assign wr_data = w;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= '0;
      max_magnitude <= '0;
      bank          <= 1'b0;
      q_wr          <= 1'b0;
      q_rd          <= 1'b0;
      q_cnt         <= '0;
    end else begin
      if (accept) begin
        if (s_axis_tlast) begin
          row_count     <= '0;
          max_magnitude <= '0;
          bank          <= ~bank;
          q_wr          <= ~q_wr;
        end else begin
          row_count     <= count_next;
          max_magnitude <= max_next;
        end
      end
      if (job_pop) q_rd <= ~q_rd;
      q_cnt <= q_cnt + 2'(push) - 2'(job_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr] <= '{bank: bank, count: count_next, maxabs: max_next,
                       bias: s_axis_tdata[63:32]};
    end
  end

  assign job_valid = q_cnt != 2'd0;
  assign job       = q_mem[q_rd];

endmodule

// ===== hdl/pcwq_back.sv =====
// Back end: replays a queued row into codes, then builds the summary item.
// Depends on pcwq_pkg; drives the shared divider and the output register.
module pcwq_back (
  input  logic                        clk,
  input  logic                        rst,
  input  pcwq_pkg::cfg_t              cfg,
  input  logic                        job_valid,
  input  pcwq_pkg::job_t              job_in,
  output logic                        job_pop,
  output logic                        rd_en,
  output logic [pcwq_pkg::ADDR_W-1:0] rd_addr,
  input  logic [31:0]                 rd_data,
  output pcwq_pkg::div_req_t          div_req,
  input  pcwq_pkg::div_res_t          div_res,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [95:0]                 m_axis_tdata,
  output logic [1:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);

  localparam logic [50:0] MAG_CAP_W = pcwq_pkg::MAG_CAP;

  pcwq_pkg::state_t state, state_next;

  pcwq_pkg::job_t               job;
  logic [14:0]                  qmax;
  logic                         zr;
  logic [pcwq_pkg::CNT_W-1:0]   idx;
  logic signed [pcwq_pkg::SUM_W-1:0] sum;
  logic                         wneg;
  logic [46:0]                  cprod;
  logic [15:0]                  code;
  logic [63:0]                  pprod;
  logic [63:0]                  mprod;
  logic [20:0]                  s;
  logic [31:0]                  sc;
  logic [47:0]                  a;
  logic [30:0]                  remf;
  logic [51:0]                  rs;
  logic [52:0]                  plo;
  logic [36:0]                  phi;
  logic [20:0]                  frac;
  logic [50:0]                  mag;
  logic [47:0]                  fb;

  logic        out_free;
  logic        load_code;
  logic        load_sum;
  logic [31:0] wmag;
  logic [31:0] shmag;
  logic [47:0] n_code;
  logic [64:0] n_sc;
  logic [48:0] nh;
  logic        sc_sat;
  logic [53:0] x_frac;
  logic [69:0] total;
  logic signed [51:0] term;
  logic signed [52:0] fbw;
  logic        last_code;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign wmag      = rd_data[31] ? 32'(32'd0 - rd_data) : rd_data;
  assign shmag     = cfg.input_shift[31] ? 32'(32'd0 - cfg.input_shift) : cfg.input_shift;
  assign n_code    = {cprod, 1'b0} + 48'(job.maxabs);
  assign n_sc      = 65'(pprod) + (65'(qmax) << 15);
  assign nh        = n_sc[64:16];
  assign sc_sat    = nh[48:32] >= 17'(qmax);
  assign x_frac    = {1'b0, rs, 1'b0} + (54'(qmax) << 16);
  assign total     = (70'(phi) << 32) + 70'(plo) + 70'(frac);
  assign term      = (cfg.input_shift[31] ^ sum[pcwq_pkg::SUM_W-1])
                     ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign fbw       = 53'(term) + 53'($signed(job.bias));
  assign last_code = idx == job.count - 1'b1;
  assign rd_addr   = {job.bank, idx[pcwq_pkg::IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) state <= pcwq_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcwq_pkg::ST_IDLE:   if (job_valid) state_next = pcwq_pkg::ST_RD;
      pcwq_pkg::ST_RD:     state_next = pcwq_pkg::ST_MUL;
      pcwq_pkg::ST_MUL:    state_next = pcwq_pkg::ST_CGO;
      pcwq_pkg::ST_CGO:    state_next = zr ? pcwq_pkg::ST_CEMIT : pcwq_pkg::ST_CWAIT;
      pcwq_pkg::ST_CWAIT:  if (div_res.done) state_next = pcwq_pkg::ST_CEMIT;
      pcwq_pkg::ST_CEMIT:  if (out_free)
                             state_next = last_code ? pcwq_pkg::ST_SMUL : pcwq_pkg::ST_RD;
      pcwq_pkg::ST_SMUL:   state_next = pcwq_pkg::ST_SCGO;
      pcwq_pkg::ST_SCGO:   state_next = sc_sat ? pcwq_pkg::ST_AGO : pcwq_pkg::ST_SCWAIT;
      pcwq_pkg::ST_SCWAIT: if (div_res.done) state_next = pcwq_pkg::ST_AGO;
      pcwq_pkg::ST_AGO:    state_next = pcwq_pkg::ST_AWAIT;
      pcwq_pkg::ST_AWAIT:  if (div_res.done) state_next = pcwq_pkg::ST_PMUL1;
      pcwq_pkg::ST_PMUL1:  state_next = pcwq_pkg::ST_PMUL2;
      pcwq_pkg::ST_PMUL2:  state_next = pcwq_pkg::ST_FGO;
      pcwq_pkg::ST_FGO:    state_next = pcwq_pkg::ST_FWAIT;
      pcwq_pkg::ST_FWAIT:  if (div_res.done) state_next = pcwq_pkg::ST_MAG;
      pcwq_pkg::ST_MAG:    state_next = pcwq_pkg::ST_FB;
      pcwq_pkg::ST_FB:     state_next = pcwq_pkg::ST_SEMIT;
      pcwq_pkg::ST_SEMIT:  if (out_free) state_next = pcwq_pkg::ST_IDLE;
      default:             state_next = pcwq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en     = 1'b0;
    job_pop   = 1'b0;
    load_code = 1'b0;
    load_sum  = 1'b0;
    div_req   = '0;
    unique case (state)
      pcwq_pkg::ST_RD:    rd_en = 1'b1;
      pcwq_pkg::ST_CGO: begin
        div_req.start   = !zr;
        div_req.rem0    = pcwq_pkg::DR_W'(n_code[47:16]);
        div_req.dvd     = {n_code[15:0], 33'd0};
        div_req.divisor = pcwq_pkg::DR_W'({job.maxabs, 1'b0});
        div_req.steps   = 6'd16;
      end
      pcwq_pkg::ST_CEMIT: load_code = out_free;
      pcwq_pkg::ST_SCGO: begin
        div_req.start   = !sc_sat;
        div_req.rem0    = pcwq_pkg::DR_W'(nh[48:32]);
        div_req.dvd     = {nh[31:0], 17'd0};
        div_req.divisor = pcwq_pkg::DR_W'(qmax);
        div_req.steps   = 6'd32;
      end
      pcwq_pkg::ST_AGO: begin
        div_req.start   = 1'b1;
        div_req.dvd     = {mprod[63:16], 1'b0};
        div_req.divisor = pcwq_pkg::DR_W'(qmax);
        div_req.steps   = 6'd48;
      end
      pcwq_pkg::ST_FGO: begin
        div_req.start   = 1'b1;
        div_req.rem0    = pcwq_pkg::DR_W'(x_frac[53:21]);
        div_req.dvd     = {x_frac[20:0], 28'd0};
        div_req.divisor = pcwq_pkg::DR_W'(qmax) << 17;
        div_req.steps   = 6'd21;
      end
      pcwq_pkg::ST_SEMIT: begin
        load_sum = out_free;
        job_pop  = out_free;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      pcwq_pkg::ST_IDLE: begin
        job  <= job_in;
        qmax <= pcwq_pkg::qmax_of(cfg.bit_width);
        zr   <= job_in.maxabs == 32'd0;
        idx  <= '0;
        sum  <= '0;
      end
      pcwq_pkg::ST_MUL: begin
        wneg  <= rd_data[31];
        cprod <= 47'(wmag) * 47'(qmax);
      end
      pcwq_pkg::ST_CGO:   if (zr) code <= '0;
      pcwq_pkg::ST_CWAIT:
        if (div_res.done) code <= wneg ? 16'(16'd0 - div_res.quot[15:0]) : div_res.quot[15:0];
      pcwq_pkg::ST_CEMIT: if (out_free) begin
        sum <= sum + pcwq_pkg::SUM_W'($signed(code));
        idx <= idx + 1'b1;
      end
      pcwq_pkg::ST_SMUL: begin
        pprod <= cfg.input_scale * job.maxabs;
        mprod <= shmag * job.maxabs;
        s     <= sum[pcwq_pkg::SUM_W-1] ? 21'(-sum) : 21'(sum);
      end
      pcwq_pkg::ST_SCGO:   if (sc_sat) sc <= 32'hFFFF_FFFF;
      pcwq_pkg::ST_SCWAIT: if (div_res.done) sc <= div_res.quot[31:0];
      pcwq_pkg::ST_AWAIT: if (div_res.done) begin
        a    <= div_res.quot[47:0];
        remf <= {div_res.rem[14:0], mprod[15:0]};
      end
      pcwq_pkg::ST_PMUL1: begin
        plo <= a[31:0] * s;
        rs  <= remf * s;
      end
      pcwq_pkg::ST_PMUL2: phi <= a[47:32] * s;
      pcwq_pkg::ST_FWAIT: if (div_res.done) frac <= div_res.quot[20:0];
      pcwq_pkg::ST_MAG:   mag <= (total > 70'(MAG_CAP_W)) ? MAG_CAP_W : total[50:0];
      pcwq_pkg::ST_FB: begin
        if (fbw > pcwq_pkg::FB_MAX)      fb <= pcwq_pkg::FB_MAX[47:0];
        else if (fbw < pcwq_pkg::FB_MIN) fb <= pcwq_pkg::FB_MIN[47:0];
        else                             fb <= fbw[47:0];
      end
      default: ;
    endcase
  end

  // output register: code items carry zero scale and bias
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_code || load_sum) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_code) begin
      m_axis_tdata <= {48'd0, 32'd0, code};
      m_axis_tuser <= {zr, 1'b0};
      m_axis_tlast <= 1'b0;
    end else if (load_sum) begin
      m_axis_tdata <= {fb, sc, 16'd0};
      m_axis_tuser <= {zr, 1'b1};
      m_axis_tlast <= 1'b1;
    end
  end

endmodule

// ===== hdl/per_channel_weight_quantizer.sv =====
// Per-channel weight quantizer. Weights enter one per cycle into a two-bank row
// store; a row ends with a queued job. Each code then takes a store read, a multiply
// and a 16-step divide (no divide on an all-zero row); the summary takes 32, 48 and
// 21 step divides on the shared divider, the 32-step one skipped on a saturated scale.
// The next row loads while one is replayed; intake stalls when both banks hold closed rows.
// Reset (rst, sync): control cleared, registers to defaults, store not cleared.
module per_channel_weight_quantizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pcwq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,  // weight_value, channel_bias
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [95:0]                    m_axis_tdata,  // weight_code, out_scale, folded_bias
  output logic [1:0]                     m_axis_tuser,  // is_summary, zero_row
  output logic                           m_axis_tlast
);

  pcwq_pkg::cfg_t     cfg;
  logic                        wr_en;
  logic [pcwq_pkg::ADDR_W-1:0] wr_addr;
  logic [31:0]                 wr_data;
  logic                        rd_en;
  logic [pcwq_pkg::ADDR_W-1:0] rd_addr;
  logic [31:0]                 rd_data;
  logic                        job_valid;
  logic                        job_pop;
  pcwq_pkg::job_t              job;
  pcwq_pkg::div_req_t          div_req;
  pcwq_pkg::div_res_t          div_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_width   <= 5'd8;
      cfg.input_scale <= 32'd65536;
      cfg.input_shift <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcwq_pkg::REG_BIT_WIDTH:   cfg.bit_width   <= cfg_data[4:0];
        pcwq_pkg::REG_INPUT_SCALE: cfg.input_scale <= cfg_data;
        pcwq_pkg::REG_INPUT_SHIFT: cfg.input_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  pcwq_front u_front (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .wr_en, .wr_addr, .wr_data, .job_valid, .job, .job_pop
  );

  pcwq_row_buf u_row_buf (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_en, .rd_addr, .rd_data
  );

  pcwq_div u_div (.clk, .rst, .req(div_req), .res(div_res));

  pcwq_back u_back (
    .clk, .rst, .cfg, .job_valid, .job_in(job), .job_pop, .rd_en, .rd_addr,
    .rd_data, .div_req, .div_res, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

endmodule

// ===== hdl/pcwq_checker.sv =====
// Port-level checks for the quantizer, bound to the top level.
// Depends on pcwq_pkg for the register index width.
module pcwq_props (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_we,
  input logic [pcwq_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                    cfg_data,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [63:0]                    s_axis_tdata,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [95:0]                    m_axis_tdata,
  input logic [1:0]                     m_axis_tuser,
  input logic                           m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[0] == m_axis_tlast)
    else $error("summary item and row end marker disagree");

  a_code_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[95:16] == 80'd0)
    else $error("code item carries scale or bias");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind per_channel_weight_quantizer pcwq_props u_pcwq_props (.*);

// ===== bench/pcwq_checker.sv =====
// Scoreboard for the per-channel weight quantizer: watches config writes and both
// stream channels, predicts codes and row summaries, compares results in order.
// Depends on pcwq_pkg for the register indexes, ROW_MAX and MAG_CAP.
`timescale 1ns / 1ps
module pcwq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          errors,
  output int          pending
);

  typedef struct {
    bit               summ;
    bit signed [15:0] code;
    bit [31:0]        scale;
    bit [47:0]        fbias;
    bit               zr;
    bit               fin;
  } qres_t;

  qres_t     want_q[$];
  bit [4:0]  bw_reg;
  bit [31:0] iscale_reg, ishift_reg;
  bit [31:0] weights[pcwq_pkg::ROW_MAX];
  int        wcount;
  bit [31:0] peak;

  function automatic bit [31:0] mag32(bit [31:0] v);
    return v[31] ? (~v + 1) : v;
  endfunction

  // close the current row: push every code, then the summary
  task automatic close_row(bit [31:0] bias);
    int        bits;
    longint    qmax, code, codesum, shv, fb;
    bit [63:0] mx, m, mg, den, a, rem, sabs, sc;
    bit        neg;
    qres_t     r;
    bits = bw_reg;
    if (bits < 2) bits = 2;
    if (bits > 16) bits = 16;
    qmax = (64'd1 << (bits - 1)) - 1;
    mx = peak;
    codesum = 0;
    for (int i = 0; i < wcount; i++) begin
      if (mx == 0) code = 0;
      else begin
        mg = (2 * 64'(mag32(weights[i])) * qmax + mx) / (2 * mx);
        code = weights[i][31] ? -longint'(mg) : longint'(mg);
        if (code > qmax) code = qmax;
        if (code < -qmax - 1) code = -qmax - 1;
      end
      codesum += code;
      r = '{0, 16'(code), 0, 0, mx == 0, 0};
      want_q.push_back(r);
    end
    den = 64'(qmax) * 65536;
    sc = (64'(iscale_reg) * mx + den / 2) / den;
    if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
    shv = longint'($signed(ishift_reg));
    neg = (shv < 0) != (codesum < 0);
    m = 64'(shv < 0 ? -shv : shv) * mx;
    sabs = 64'(codesum < 0 ? -codesum : codesum);
    a = m / den;
    rem = m % den;
    if (sabs != 0 && a > pcwq_pkg::MAG_CAP / sabs) mg = pcwq_pkg::MAG_CAP;
    else begin
      mg = a * sabs + (2 * rem * sabs + den) / (2 * den);
      if (mg > pcwq_pkg::MAG_CAP) mg = pcwq_pkg::MAG_CAP;
    end
    fb = (neg ? -longint'(mg) : longint'(mg)) + longint'($signed(bias));
    if (fb > 64'sh7FFF_FFFF_FFFF) fb = 64'sh7FFF_FFFF_FFFF;
    if (fb < -64'sh8000_0000_0000) fb = -64'sh8000_0000_0000;
    r = '{1, 0, sc[31:0], 48'(fb), mx == 0, 1};
    want_q.push_back(r);
    wcount = 0;
    peak = 0;
  endtask

  always @(posedge clk) begin
    qres_t e;
    bit [31:0] wv;
    if (rst) begin
      bw_reg = 8;
      iscale_reg = 65536;
      ishift_reg = 0;
      wcount = 0;
      peak = 0;
      want_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pcwq_pkg::REG_BIT_WIDTH:   bw_reg = cfg_data[4:0];
          pcwq_pkg::REG_INPUT_SCALE: iscale_reg = cfg_data;
          pcwq_pkg::REG_INPUT_SHIFT: ishift_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        wv = s_axis_tdata[31:0];
        if (wcount < pcwq_pkg::ROW_MAX) begin
          weights[wcount] = wv;
          wcount++;
          if (mag32(wv) > peak) peak = mag32(wv);
        end
        if (s_axis_tlast) close_row(s_axis_tdata[63:32]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result item %h", m_axis_tdata);
          errors++;
        end else begin
          e = want_q.pop_front();
          if (m_axis_tuser[0] !== e.summ) begin
            $error("is_summary: expected %0d, got %0d", e.summ, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tdata[15:0] !== e.code) begin
            $error("weight_code: expected %0d, got %0d", e.code,
                   $signed(m_axis_tdata[15:0]));
            errors++;
          end
          if (m_axis_tdata[47:16] !== e.scale) begin
            $error("out_scale: expected %h, got %h", e.scale, m_axis_tdata[47:16]);
            errors++;
          end
          if (m_axis_tdata[95:48] !== e.fbias) begin
            $error("folded_bias: expected %h, got %h", e.fbias, m_axis_tdata[95:48]);
            errors++;
          end
          if (m_axis_tuser[1] !== e.zr) begin
            $error("zero_row: expected %0d, got %0d", e.zr, m_axis_tuser[1]);
            errors++;
          end
          if (m_axis_tlast !== e.fin) begin
            $error("final_result: expected %0d, got %0d", e.fin, m_axis_tlast);
            errors++;
          end
        end
      end
    end
    pending = want_q.size();
  end
endmodule

// ===== bench/per_channel_weight_quantizer_test.sv =====
// Top of the quantizer bench: clock, reset, config phases, row stimulus with
// random gaps and stalls, watchdog and verdict. Needs pcwq_pkg, the DUT, pcwq_checker.
`timescale 1ns / 1ps
module per_channel_weight_quantizer_test;

  localparam int WDOG_LIMIT = 6000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = pcwq_pkg::REG_BIT_WIDTH;
  logic [31:0] cfg_data = 0;
  logic        s_valid = 0, s_ready, s_last = 0;
  logic [63:0] s_data = 0;
  logic        m_valid, m_ready = 0, m_last;
  logic [95:0] m_data;
  logic [1:0]  m_user;
  int          errors, pending;
  int          s_idle = 0, r_stall = 0, items_sent = 0, quiet = 0;
  bit          hold_req = 0;

  always #6 clk = ~clk;

  per_channel_weight_quantizer DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .s_axis_tlast(s_last), .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last));

  pcwq_checker scb (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .s_axis_tlast(s_last), .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last),
    .errors(errors), .pending(pending));

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      m_ready <= 0;
      repeat (500) @(negedge clk);
      hold_req = 0;
    end else begin
      m_ready <= ($urandom_range(99) >= r_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("** per_channel_weight_quantizer: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic send_weight(logic [31:0] w, logic [31:0] b, logic last);
    while ($urandom_range(99) < s_idle) begin
      s_valid = 0;
      @(negedge clk);
    end
    s_valid = 1;
    s_data <= {b, w};
    s_last <= last;
    do @(posedge clk); while (!s_ready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(7))
      0: return 0;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom) >>> $urandom_range(31));
    endcase
  endfunction

  task automatic send_row(int len, bit zero_only);
    for (int i = 0; i < len; i++)
      send_weight(zero_only ? 32'd0 : rand_weight(), $urandom, i == len - 1);
    s_valid = 0;
  endtask

  // let the block drain before touching registers
  task automatic settle();
    s_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  initial begin
    int goal;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: extremes and special rows at the reset settings
    send_weight(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_weight(32'h8000_0000, 32'h8000_0000, 0);
    send_weight(32'h0000_0001, 32'h8000_0000, 1);
    send_weight(32'h0001_0000, 32'h0, 1);
    send_row(3, 1);
    settle();
    write_reg(pcwq_pkg::REG_BIT_WIDTH, 32'd2);
    write_reg(pcwq_pkg::REG_INPUT_SCALE, 32'hFFFF_FFFF);
    write_reg(pcwq_pkg::REG_INPUT_SHIFT, 32'h7FFF_FFFF);
    send_weight(32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
    send_weight(32'h0000_8000, 32'h7FFF_FFFF, 1);
    send_row(4, 0);
    settle();
    write_reg(pcwq_pkg::REG_BIT_WIDTH, 32'd16);
    write_reg(pcwq_pkg::REG_INPUT_SCALE, 32'd0);
    write_reg(pcwq_pkg::REG_INPUT_SHIFT, 32'h8000_0000);
    send_weight(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_weight(32'h8000_0000, 32'h8000_0000, 1);
    settle();
    write_reg(pcwq_pkg::REG_BIT_WIDTH, 32'd1);
    send_row(2, 0);
    settle();
    write_reg(pcwq_pkg::REG_BIT_WIDTH, 32'd31);
    send_row(36, 0);  // overlong row, tail ignored
    settle();

    goal = items_sent + 200;
    for (int ph = 0; items_sent < goal; ph++) begin
      case (ph % 4)
        0: begin s_idle = 0;  r_stall = 0;  end
        1: begin s_idle = 54; r_stall = 0;  end
        2: begin s_idle = 0;  r_stall = 54; end
        default: begin s_idle = 9; r_stall = 9; end
      endcase
      write_reg(pcwq_pkg::REG_BIT_WIDTH,
                $urandom_range(4) == 0 ? $urandom : $urandom_range(2, 16));
      write_reg(pcwq_pkg::REG_INPUT_SCALE,
                $urandom_range(1) ? $urandom : $urandom_range(0, 1 << 18));
      write_reg(pcwq_pkg::REG_INPUT_SHIFT, $urandom_range(1) ? $urandom
                                 : 32'($signed($urandom) >>> $urandom_range(31)));
      if (ph == 1) hold_req = 1;
      repeat (3 + $urandom_range(3)) begin
        if ($urandom_range(9) == 0) send_row($urandom_range(33, 40), 0);
        else send_row($urandom_range(1, 12), $urandom_range(11) == 0);
        if ($urandom_range(3) == 0) repeat ($urandom_range(20)) @(negedge clk);
      end
      settle();
    end

    s_idle = 0;
    r_stall = 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) $display("** per_channel_weight_quantizer: PASSED **");
    else $display("** per_channel_weight_quantizer: FAILED **");
    $finish;
  end
endmodule
